/* src/owtr_pkg.sv */
// ----------------------------------------------------------------------------
// owtr_pkg: shared types and constants for the one-wire temperature reader
// Phase and command codes, register map, timing constants and the duration
// clamp used by the bus engine.
// ----------------------------------------------------------------------------
package owtr_pkg;

   localparam int TickCountBits = 20;
   localparam int DurWidth      = TickCountBits + 1;

   localparam int CsrIndexWidth = 3;

   localparam logic [7:0] WriteOneRelease = 8'd55;
   localparam logic [7:0] ReadTail        = 8'd30;
   localparam logic [6:0] DegreeMask      = 7'h7F;

   localparam logic [7:0] CmdSkip    = 8'hCC;
   localparam logic [7:0] CmdConvert = 8'h44;
   localparam logic [7:0] CmdScratch = 8'hBE;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_RESET_LOW      = 3'd0,
      REG_PRESENCE_SAMPLE = 3'd1,
      REG_RESET_TAIL     = 3'd2,
      REG_ZERO_LOW       = 3'd3,
      REG_SHORT_LOW      = 3'd4,
      REG_READ_SAMPLE    = 3'd5,
      REG_CONVERSION     = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_RESET = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_TEMP  = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_REL  = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_W_LOW    = 4'd4,
      PH_W_REL    = 4'd5,
      PH_R_LOW    = 4'd6,
      PH_R_REL    = 4'd7,
      PH_R_TAIL   = 4'd8,
      PH_CONV     = 4'd9
   } phase_type;

   typedef enum logic [3:0] {
      SQ_RESET1  = 4'd0,
      SQ_SKIP1   = 4'd1,
      SQ_CONVERT = 4'd2,
      SQ_WAIT    = 4'd3,
      SQ_RESET2  = 4'd4,
      SQ_SKIP2   = 4'd5,
      SQ_SCRATCH = 4'd6,
      SQ_READ_LO = 4'd7,
      SQ_READ_HI = 4'd8
   } seq_type;

   typedef struct packed {
      logic [11:0] reset_low_us;
      logic [11:0] presence_sample_us;
      logic [11:0] reset_tail_us;
      logic [7:0]  zero_low_us;
      logic [7:0]  short_low_us;
      logic [7:0]  read_sample_us;
      logic [19:0] conversion_wait_us;
   } cfg_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        presence;
      logic [7:0]  rx_byte;
      logic [15:0] temperature_raw;
      logic [6:0]  whole_degrees;
   } result_type;

   // Zero counts as one tick; anything above 2^TickCountBits is capped there.
   function automatic logic [DurWidth-1:0] clamp_dur(input logic [19:0] d);
      logic [32:0] v;
      logic [32:0] lim;
      lim = 33'(1) << TickCountBits;
      v   = (d == 20'd0) ? 33'd1 : 33'(d);
      if (v > lim) begin
         v = lim;
      end
      return v[DurWidth-1:0];
   endfunction

endpackage

/* src/owtr_csr.sv */
// ----------------------------------------------------------------------------
// owtr_csr: timing register file
// Holds the seven bus timing registers; a write is taken every cycle.
// ----------------------------------------------------------------------------
module owtr_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [owtr_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [31:0]                            csr_data,
   output owtr_pkg::cfg_type                      cfg
);

   owtr_pkg::cfg_type cfg_ff;
   owtr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            owtr_pkg::REG_RESET_LOW:       cfg_in.reset_low_us       = csr_data[11:0];
            owtr_pkg::REG_PRESENCE_SAMPLE: cfg_in.presence_sample_us = csr_data[11:0];
            owtr_pkg::REG_RESET_TAIL:      cfg_in.reset_tail_us      = csr_data[11:0];
            owtr_pkg::REG_ZERO_LOW:        cfg_in.zero_low_us        = csr_data[7:0];
            owtr_pkg::REG_SHORT_LOW:       cfg_in.short_low_us       = csr_data[7:0];
            owtr_pkg::REG_READ_SAMPLE:     cfg_in.read_sample_us     = csr_data[7:0];
            owtr_pkg::REG_CONVERSION:      cfg_in.conversion_wait_us = csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us       <= 12'd485;
         cfg_ff.presence_sample_us <= 12'd65;
         cfg_ff.reset_tail_us      <= 12'd420;
         cfg_ff.zero_low_us        <= 8'd60;
         cfg_ff.short_low_us       <= 8'd5;
         cfg_ff.read_sample_us     <= 8'd15;
         cfg_ff.conversion_wait_us <= 20'd750000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/owtr_engine.sv */
// ----------------------------------------------------------------------------
// owtr_engine: one-wire bus sequencer
// Advances the slot state machine by one tick per step and forms the result
// of that tick.
// ----------------------------------------------------------------------------
module owtr_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [2:0]            op,
   input  logic [7:0]            tx_byte,
   input  logic                  line_in,
   input  owtr_pkg::cfg_type     cfg,
   output owtr_pkg::result_type  result
);

   localparam int TB = owtr_pkg::TickCountBits;
   localparam int DW = owtr_pkg::DurWidth;

   owtr_pkg::phase_type phase_ff, phase_in, eff_phase;
   owtr_pkg::seq_type   step_ff, step_in, eff_step;
   logic [2:0]          cmd_ff, cmd_in, eff_cmd;
   logic [TB-1:0]       tick_ff, tick_in, eff_tick;
   logic [2:0]          bit_ff, bit_in, eff_bit;
   logic [7:0]          shift_ff, shift_in, eff_shift;
   logic [15:0]         temp_ff, temp_in;
   logic                pres_ff, pres_in;
   logic [7:0]          rx_ff, rx_in;

   logic                busy, drive, done;
   logic                cur_bit;
   logic [19:0]         raw_dur;
   logic [DW-1:0]       dur;
   logic                last_tick;
   logic                last_bit;

   // Start decode: a command from idle already uses this tick.
   always_comb begin
      eff_phase = phase_ff;
      eff_step  = step_ff;
      eff_cmd   = cmd_ff;
      eff_tick  = tick_ff;
      eff_bit   = bit_ff;
      eff_shift = shift_ff;
      if (phase_ff == owtr_pkg::PH_IDLE && (op inside {[owtr_pkg::OP_RESET:owtr_pkg::OP_TEMP]}))
      begin
         eff_cmd  = op;
         eff_step = owtr_pkg::SQ_RESET1;
         eff_tick = '0;
         case (op)
            owtr_pkg::OP_WRITE: begin
               eff_shift = tx_byte;
               eff_bit   = 3'd0;
               eff_phase = owtr_pkg::PH_W_LOW;
            end
            owtr_pkg::OP_READ: begin
               eff_shift = 8'd0;
               eff_bit   = 3'd0;
               eff_phase = owtr_pkg::PH_R_LOW;
            end
            default: eff_phase = owtr_pkg::PH_RST_LOW;
         endcase
      end
   end

   // Outputs and slot length of the current phase.
   always_comb begin
      cur_bit = eff_shift[eff_bit];
      busy    = (eff_phase != owtr_pkg::PH_IDLE);
      drive   = (eff_phase == owtr_pkg::PH_RST_LOW) || (eff_phase == owtr_pkg::PH_W_LOW) ||
                (eff_phase == owtr_pkg::PH_R_LOW);
      case (eff_phase)
         owtr_pkg::PH_RST_LOW:  raw_dur = 20'(cfg.reset_low_us);
         owtr_pkg::PH_RST_REL:  raw_dur = 20'(cfg.presence_sample_us);
         owtr_pkg::PH_RST_TAIL: raw_dur = 20'(cfg.reset_tail_us);
         owtr_pkg::PH_W_LOW:    raw_dur = cur_bit ? 20'(cfg.short_low_us)
                                                  : 20'(cfg.zero_low_us);
         owtr_pkg::PH_W_REL:    raw_dur = cur_bit ? 20'(owtr_pkg::WriteOneRelease)
                                                  : 20'(cfg.short_low_us);
         owtr_pkg::PH_R_LOW:    raw_dur = 20'(cfg.short_low_us);
         owtr_pkg::PH_R_REL:    raw_dur = 20'(cfg.read_sample_us);
         owtr_pkg::PH_R_TAIL:   raw_dur = 20'(owtr_pkg::ReadTail);
         owtr_pkg::PH_CONV:     raw_dur = cfg.conversion_wait_us;
         default:               raw_dur = 20'd1;
      endcase
      dur       = owtr_pkg::clamp_dur(raw_dur);
      last_tick = ((33'(eff_tick) + 33'd1) >= 33'(dur));
      last_bit  = (eff_bit == 3'd7);
   end

   // Next state.
   always_comb begin
      phase_in = eff_phase;
      step_in  = eff_step;
      cmd_in   = eff_cmd;
      tick_in  = eff_tick;
      bit_in   = eff_bit;
      shift_in = eff_shift;
      temp_in  = temp_ff;
      pres_in  = pres_ff;
      rx_in    = rx_ff;
      done     = 1'b0;

      if (busy) begin
         // Sample on the first tick of the tail slots.
         if (eff_tick == '0) begin
            if (eff_phase == owtr_pkg::PH_RST_TAIL) begin
               pres_in = !line_in;
            end else if (eff_phase == owtr_pkg::PH_R_TAIL && line_in) begin
               shift_in[eff_bit] = 1'b1;
            end
         end

         if (last_tick) begin
            tick_in = '0;
            case (eff_phase)
               owtr_pkg::PH_RST_LOW: phase_in = owtr_pkg::PH_RST_REL;
               owtr_pkg::PH_RST_REL: phase_in = owtr_pkg::PH_RST_TAIL;
               owtr_pkg::PH_W_LOW:   phase_in = owtr_pkg::PH_W_REL;
               owtr_pkg::PH_R_LOW:   phase_in = owtr_pkg::PH_R_REL;
               owtr_pkg::PH_R_REL:   phase_in = owtr_pkg::PH_R_TAIL;
               default: begin
                  if ((eff_phase == owtr_pkg::PH_W_REL || eff_phase == owtr_pkg::PH_R_TAIL)
                      && !last_bit) begin
                     bit_in   = eff_bit + 3'd1;
                     phase_in = (eff_phase == owtr_pkg::PH_W_REL) ? owtr_pkg::PH_W_LOW
                                                                  : owtr_pkg::PH_R_LOW;
                  end else if (eff_cmd != owtr_pkg::OP_TEMP) begin
                     // Single operation ends here.
                     if (eff_cmd == owtr_pkg::OP_READ) begin
                        rx_in = shift_in;
                     end
                     phase_in = owtr_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     case (eff_step)
                        owtr_pkg::SQ_RESET1: begin
                           if (!pres_in) begin
                              temp_in  = 16'd0;
                              phase_in = owtr_pkg::PH_IDLE;
                              done     = 1'b1;
                           end else begin
                              step_in  = owtr_pkg::SQ_SKIP1;
                              shift_in = owtr_pkg::CmdSkip;
                              bit_in   = 3'd0;
                              phase_in = owtr_pkg::PH_W_LOW;
                           end
                        end
                        owtr_pkg::SQ_SKIP1: begin
                           step_in  = owtr_pkg::SQ_CONVERT;
                           shift_in = owtr_pkg::CmdConvert;
                           bit_in   = 3'd0;
                           phase_in = owtr_pkg::PH_W_LOW;
                        end
                        owtr_pkg::SQ_CONVERT: begin
                           step_in  = owtr_pkg::SQ_WAIT;
                           phase_in = owtr_pkg::PH_CONV;
                        end
                        owtr_pkg::SQ_WAIT: begin
                           step_in  = owtr_pkg::SQ_RESET2;
                           phase_in = owtr_pkg::PH_RST_LOW;
                        end
                        owtr_pkg::SQ_RESET2: begin
                           step_in  = owtr_pkg::SQ_SKIP2;
                           shift_in = owtr_pkg::CmdSkip;
                           bit_in   = 3'd0;
                           phase_in = owtr_pkg::PH_W_LOW;
                        end
                        owtr_pkg::SQ_SKIP2: begin
                           step_in  = owtr_pkg::SQ_SCRATCH;
                           shift_in = owtr_pkg::CmdScratch;
                           bit_in   = 3'd0;
                           phase_in = owtr_pkg::PH_W_LOW;
                        end
                        owtr_pkg::SQ_SCRATCH: begin
                           step_in  = owtr_pkg::SQ_READ_LO;
                           shift_in = 8'd0;
                           bit_in   = 3'd0;
                           phase_in = owtr_pkg::PH_R_LOW;
                        end
                        owtr_pkg::SQ_READ_LO: begin
                           rx_in    = shift_in;
                           step_in  = owtr_pkg::SQ_READ_HI;
                           shift_in = 8'd0;
                           bit_in   = 3'd0;
                           phase_in = owtr_pkg::PH_R_LOW;
                        end
                        default: begin
                           temp_in  = {shift_in, rx_ff};
                           rx_in    = shift_in;
                           phase_in = owtr_pkg::PH_IDLE;
                           done     = 1'b1;
                        end
                     endcase
                  end
               end
            endcase
         end else begin
            tick_in = eff_tick + 1'b1;
         end
      end
   end

   always_comb begin
      result.drive_low       = drive;
      result.busy_res        = busy;
      result.done_res        = done;
      result.presence        = pres_in;
      result.rx_byte         = rx_in;
      result.temperature_raw = temp_in;
      result.whole_degrees   = temp_in[10:4] & owtr_pkg::DegreeMask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owtr_pkg::PH_IDLE;
         step_ff  <= owtr_pkg::SQ_RESET1;
         cmd_ff   <= owtr_pkg::OP_TICK;
         tick_ff  <= '0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         temp_ff  <= 16'd0;
         pres_ff  <= 1'b0;
         rx_ff    <= 8'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         cmd_ff   <= cmd_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         temp_ff  <= temp_in;
         pres_ff  <= pres_in;
         rx_ff    <= rx_in;
      end
   end

endmodule

/* src/one_wire_master_temp_read.sv */
// ----------------------------------------------------------------------------
// one_wire_master_temp_read: one-wire bus master with temperature read
// Tick-driven master for reset/presence, byte write, byte read and a full
// temperature conversion and scratchpad read.
// ----------------------------------------------------------------------------
//
//   channel  direction  carries
//   -------  ---------  ---------------------------------------------------
//   req_     in         one tick: op, tx_byte, sampled line level
//   rsp_     out        that tick: drive, busy, done, presence, rx, temp
//   csr_     in         timing register write: index and data
//
// One item per clock sustained while the result is not stalled: the bus
// sequencer works on an item while it sits in the input register, and the
// result register takes it when the result slot is free or draining.
// Reset (synchronous) empties both registers, idles the sequencer and loads
// the default timings. A stalled result holds the input register; while that
// register is full too, req_ready drops. Timing writes are taken every cycle.
//
module one_wire_master_temp_read (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_op,
   input  logic [7:0]                         req_tx_byte,
   input  logic                               req_line_in,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_drive_low,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic                               rsp_presence,
   output logic [7:0]                         rsp_rx_byte,
   output logic [15:0]                        rsp_temperature_raw,
   output logic [6:0]                         rsp_whole_degrees,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [owtr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                        csr_data
);

   owtr_pkg::cfg_type    cfg;
   owtr_pkg::result_type result;
   owtr_pkg::result_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] op_ff;
   logic [7:0] tx_ff;
   logic       line_ff;

   logic       advance;
   logic       fire;
   logic       req_take;

   // Move the held item forward whenever the result slot is free or draining.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   owtr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   owtr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .op      (op_ff),
      .tx_byte (tx_ff),
      .line_in (line_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture on acceptance, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_op;
         tx_ff   <= req_tx_byte;
         line_ff <= req_line_in;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_low       = rsp_ff.drive_low;
   assign rsp_busy_res        = rsp_ff.busy_res;
   assign rsp_done_res        = rsp_ff.done_res;
   assign rsp_presence        = rsp_ff.presence;
   assign rsp_rx_byte         = rsp_ff.rx_byte;
   assign rsp_temperature_raw = rsp_ff.temperature_raw;
   assign rsp_whole_degrees   = rsp_ff.whole_degrees;

endmodule

/* src/owtr_checker.sv */
// ----------------------------------------------------------------------------
// owtr_checker: port-level checks for the one-wire master
// Watches the result channel and relations among its fields.
// ----------------------------------------------------------------------------
module owtr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_drive_low,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [15:0] rsp_temperature_raw,
   input logic [6:0]  rsp_whole_degrees
);

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature_raw)
         && $stable(rsp_done_res))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("bus driven while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_whole_degrees == rsp_temperature_raw[10:4])
      else $error("whole degrees disagree with raw value");

endmodule

bind one_wire_master_temp_read owtr_checker u_owtr_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_drive_low       (rsp_drive_low),
   .rsp_busy_res        (rsp_busy_res),
   .rsp_done_res        (rsp_done_res),
   .rsp_temperature_raw (rsp_temperature_raw),
   .rsp_whole_degrees   (rsp_whole_degrees)
);
